// File: sv/bvtm_pkg.sv
// ----------------------------------------------------------------------------
// bvtm_pkg
// Shared types and constants for the battery voltage trend monitor.
// ----------------------------------------------------------------------------
package bvtm_pkg;

    localparam int MV_W      = 15;
    localparam int SEC_W     = 31;
    localparam int STAMP_W   = 32;
    localparam int PERIOD_W  = 8;
    localparam int APB_DW    = 32;
    localparam int PADDR_W   = 4;

    // 24 hour window for the max/min tracking
    localparam int WINDOW_SECONDS = 24 * 60 * 60;

    // averaging window
    localparam int AVG_WINDOW  = 6;
    localparam int SLOT_W      = (AVG_WINDOW > 2) ? $clog2(AVG_WINDOW) : 1;
    localparam int SUM_W       = MV_W + $clog2(AVG_WINDOW);
    // exact divide by AVG_WINDOW: multiply by ceil(2^k / N), then shift by k
    localparam int RECIP_SHIFT = SUM_W + $clog2(AVG_WINDOW);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + AVG_WINDOW - 1) / AVG_WINDOW;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // register reset values
    localparam logic [MV_W-1:0]     FLOAT_THR_RST  = MV_W'(13200);
    localparam logic [MV_W-1:0]     CHARGE_THR_RST = MV_W'(13800);
    localparam logic [PERIOD_W-1:0] PERIOD_RST     = PERIOD_W'(45);

    // register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_FLOAT_THR  = 2'd0,
        REG_CHARGE_THR = 2'd1,
        REG_PERIOD     = 2'd2
    } reg_idx_t;

    // charge-band machine codes
    typedef enum logic [3:0] {
        BAND_IDLE       = 4'd0,
        BAND_NOT        = 4'd1,
        BAND_FLOAT      = 4'd2,
        BAND_CHARGE     = 4'd3,
        BAND_NOT_TO_CHG = 4'd4,
        BAND_FLT_TO_CHG = 4'd5,
        BAND_CHG_TO_FLT = 4'd6,
        BAND_CHG_TO_NOT = 4'd7,
        BAND_UP_DOWN    = 4'd8,
        BAND_MULTI      = 4'd9
    } band_code_t;

    typedef struct packed {
        logic [MV_W-1:0]  sample_mv;
        logic [SEC_W-1:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        logic [MV_W-1:0]           max_mv;
        logic [MV_W-1:0]           min_mv;
        logic signed [STAMP_W-1:0] last_float_time;
        logic signed [STAMP_W-1:0] last_charge_time;
        logic                      avg_valid;
        logic [MV_W-1:0]           avg_mv;
        logic                      graph_valid;
        logic [3:0]                graph_code;
    } out_item_t;

    typedef struct packed {
        logic            valid;
        logic [MV_W-1:0] mv;
    } avg_res_t;

    typedef struct packed {
        logic       valid;
        band_code_t code;
    } graph_res_t;

endpackage

// File: sv/bvtm_avg.sv
// ----------------------------------------------------------------------------
// bvtm_avg
// Running sum over the averaging window and exact divide by the window size.
// ----------------------------------------------------------------------------
module bvtm_avg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic [bvtm_pkg::MV_W-1:0]    sample_mv,
    output bvtm_pkg::avg_res_t           res
);

    logic [bvtm_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [bvtm_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [bvtm_pkg::SUM_W-1:0]   sum_total;
    logic [bvtm_pkg::PROD_W-1:0]  prod;
    logic                         last;

    localparam logic [bvtm_pkg::RECIP_W-1:0] RECIP_C = bvtm_pkg::RECIP_W'(bvtm_pkg::RECIP);
    localparam logic [bvtm_pkg::SLOT_W-1:0]  LAST_SLOT =
        bvtm_pkg::SLOT_W'(bvtm_pkg::AVG_WINDOW - 1);

    always_comb begin
        sum_total = sum_reg + bvtm_pkg::SUM_W'(sample_mv);
        last      = (slot_reg == LAST_SLOT);
        prod      = bvtm_pkg::PROD_W'(sum_total) * bvtm_pkg::PROD_W'(RECIP_C);

        res.valid = last;
        res.mv    = last ? prod[bvtm_pkg::RECIP_SHIFT +: bvtm_pkg::MV_W] : '0;

        if (last) begin
            slot_next = '0;
            sum_next  = '0;
        end else begin
            slot_next = slot_reg + 1'b1;
            sum_next  = sum_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            sum_reg  <= '0;
        end else if (advance) begin
            slot_reg <= slot_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

// File: sv/bvtm_band.sv
// ----------------------------------------------------------------------------
// bvtm_band
// Charge-band state machine with graph period counter.
// ----------------------------------------------------------------------------
module bvtm_band (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic [bvtm_pkg::MV_W-1:0]      sample_mv,
    input  logic [bvtm_pkg::MV_W-1:0]      float_thr,
    input  logic [bvtm_pkg::MV_W-1:0]      charge_thr,
    input  logic [bvtm_pkg::PERIOD_W-1:0]  graph_period,
    output bvtm_pkg::graph_res_t           res
);

    bvtm_pkg::band_code_t             state_reg, state_next;
    bvtm_pkg::band_code_t             code;
    logic                             up_reg, up_next;
    logic                             down_reg, down_next;
    logic [bvtm_pkg::PERIOD_W-1:0]    ticks_reg, ticks_next;
    logic [bvtm_pkg::PERIOD_W:0]      ticks_inc;
    logic                             period_end;
    logic                             up_now, down_now;

    always_comb begin
        ticks_inc  = {1'b0, ticks_reg} + 1'b1;
        period_end = !(ticks_inc < {1'b0, graph_period});
        ticks_next = period_end ? '0 : ticks_inc[bvtm_pkg::PERIOD_W-1:0];

        if (sample_mv >= charge_thr) begin
            code = bvtm_pkg::BAND_CHARGE;
        end else if (sample_mv >= float_thr) begin
            code = bvtm_pkg::BAND_FLOAT;
        end else begin
            code = bvtm_pkg::BAND_NOT;
        end

        up_now   = up_reg;
        down_now = down_reg;
        case (code)
            bvtm_pkg::BAND_NOT: begin
                if (state_reg == bvtm_pkg::BAND_CHARGE) begin
                    down_now = 1'b1;
                    code     = bvtm_pkg::BAND_CHG_TO_NOT;
                end
            end
            bvtm_pkg::BAND_FLOAT: begin
                if (state_reg == bvtm_pkg::BAND_CHARGE) begin
                    down_now = 1'b1;
                    code     = bvtm_pkg::BAND_CHG_TO_FLT;
                end
            end
            bvtm_pkg::BAND_CHARGE: begin
                if (state_reg == bvtm_pkg::BAND_FLOAT) begin
                    up_now = 1'b1;
                    code   = bvtm_pkg::BAND_FLT_TO_CHG;
                end else if (state_reg == bvtm_pkg::BAND_NOT) begin
                    up_now = 1'b1;
                    code   = bvtm_pkg::BAND_NOT_TO_CHG;
                end
            end
            default: ;
        endcase
        if (up_now && down_now) begin
            code = bvtm_pkg::BAND_UP_DOWN;
        end
        // any item seen while already in up/down escalates to multi
        if ((up_now || down_now) && state_reg == bvtm_pkg::BAND_UP_DOWN) begin
            code = bvtm_pkg::BAND_MULTI;
        end

        if (period_end) begin
            state_next = bvtm_pkg::BAND_IDLE;
            up_next    = 1'b0;
            down_next  = 1'b0;
        end else begin
            state_next = code;
            up_next    = up_now;
            down_next  = down_now;
        end

        res.valid = period_end;
        res.code  = period_end ? code : bvtm_pkg::BAND_IDLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bvtm_pkg::BAND_IDLE;
            up_reg    <= 1'b0;
            down_reg  <= 1'b0;
            ticks_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            up_reg    <= up_next;
            down_reg  <= down_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

// File: sv/battery_voltage_trend_monitor_top.sv
// ----------------------------------------------------------------------------
// battery_voltage_trend_monitor_top
// 24 h max/min tracking, band timestamps, window average and band graph codes.
// ----------------------------------------------------------------------------
// The result is loaded into the output register at the accepting edge, and
// m_valid rises right after it.
// Throughput: one item per cycle; the output register stalls intake only while
// a result waits and m_ready is low.
// Reset (aresetn low, synchronous): max/min and counters clear, band stamps go
// to -1, thresholds return to 13200 / 13800 mV and graph period to 45.
module battery_voltage_trend_monitor_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bvtm_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bvtm_pkg::out_item_t               m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bvtm_pkg::PADDR_W-1:0]      paddr,
    input  logic [bvtm_pkg::APB_DW-1:0]       pwdata,
    output logic [bvtm_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    logic [bvtm_pkg::MV_W-1:0]        float_thr_reg, charge_thr_reg;
    logic [bvtm_pkg::PERIOD_W-1:0]    period_reg;
    logic                             cfg_wr;
    bvtm_pkg::reg_idx_t               cfg_idx;

    logic [bvtm_pkg::MV_W-1:0]        max_val_reg, max_val_next;
    logic [bvtm_pkg::SEC_W-1:0]       max_stamp_reg, max_stamp_next;
    logic [bvtm_pkg::MV_W-1:0]        min_val_reg, min_val_next;
    logic [bvtm_pkg::SEC_W-1:0]       min_stamp_reg, min_stamp_next;
    logic                             seen_reg;
    logic [bvtm_pkg::STAMP_W-1:0]     float_stamp_reg, float_stamp_next;
    logic [bvtm_pkg::STAMP_W-1:0]     charge_stamp_reg, charge_stamp_next;
    logic signed [bvtm_pkg::STAMP_W-1:0] max_age, min_age;

    logic                             accept;
    logic                             m_valid_reg;
    bvtm_pkg::out_item_t              m_data_reg, m_data_next;
    bvtm_pkg::avg_res_t               avg_res;
    bvtm_pkg::graph_res_t             graph_res;

    localparam logic signed [bvtm_pkg::STAMP_W-1:0] WINDOW_C =
        bvtm_pkg::STAMP_W'(bvtm_pkg::WINDOW_SECONDS);

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = bvtm_pkg::reg_idx_t'(paddr[bvtm_pkg::PADDR_W-1:2]);

    always_comb begin
        case (cfg_idx)
            bvtm_pkg::REG_FLOAT_THR:  prdata = bvtm_pkg::APB_DW'(float_thr_reg);
            bvtm_pkg::REG_CHARGE_THR: prdata = bvtm_pkg::APB_DW'(charge_thr_reg);
            bvtm_pkg::REG_PERIOD:     prdata = bvtm_pkg::APB_DW'(period_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            float_thr_reg  <= bvtm_pkg::FLOAT_THR_RST;
            charge_thr_reg <= bvtm_pkg::CHARGE_THR_RST;
            period_reg     <= bvtm_pkg::PERIOD_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bvtm_pkg::REG_FLOAT_THR:  float_thr_reg  <= pwdata[bvtm_pkg::MV_W-1:0];
                bvtm_pkg::REG_CHARGE_THR: charge_thr_reg <= pwdata[bvtm_pkg::MV_W-1:0];
                bvtm_pkg::REG_PERIOD:     period_reg     <= pwdata[bvtm_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sub units ----------------
    bvtm_avg u_avg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (accept),
        .sample_mv (s_data.sample_mv),
        .res       (avg_res)
    );

    bvtm_band u_band (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept),
        .sample_mv    (s_data.sample_mv),
        .float_thr    (float_thr_reg),
        .charge_thr   (charge_thr_reg),
        .graph_period (period_reg),
        .res          (graph_res)
    );

    // ---------------- max/min window and band stamps ----------------
    always_comb begin
        // signed age; a clock that steps back gives a negative age, no expiry
        max_age = signed'({1'b0, s_data.now_seconds} - {1'b0, max_stamp_reg});
        min_age = signed'({1'b0, s_data.now_seconds} - {1'b0, min_stamp_reg});

        max_val_next   = max_val_reg;
        max_stamp_next = max_stamp_reg;
        min_val_next   = min_val_reg;
        min_stamp_next = min_stamp_reg;
        if (!seen_reg || s_data.sample_mv > max_val_reg || max_age > WINDOW_C) begin
            max_val_next   = s_data.sample_mv;
            max_stamp_next = s_data.now_seconds;
        end
        if (!seen_reg || s_data.sample_mv < min_val_reg || min_age > WINDOW_C) begin
            min_val_next   = s_data.sample_mv;
            min_stamp_next = s_data.now_seconds;
        end

        float_stamp_next  = float_stamp_reg;
        charge_stamp_next = charge_stamp_reg;
        if (s_data.sample_mv >= charge_thr_reg) begin
            charge_stamp_next = {1'b0, s_data.now_seconds};
        end else if (s_data.sample_mv >= float_thr_reg) begin
            float_stamp_next = {1'b0, s_data.now_seconds};
        end

        m_data_next.max_mv           = max_val_next;
        m_data_next.min_mv           = min_val_next;
        m_data_next.last_float_time  = signed'(float_stamp_next);
        m_data_next.last_charge_time = signed'(charge_stamp_next);
        m_data_next.avg_valid        = avg_res.valid;
        m_data_next.avg_mv           = avg_res.mv;
        m_data_next.graph_valid      = graph_res.valid;
        m_data_next.graph_code       = graph_res.code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_val_reg      <= '0;
            max_stamp_reg    <= '0;
            min_val_reg      <= '0;
            min_stamp_reg    <= '0;
            seen_reg         <= 1'b0;
            float_stamp_reg  <= '1;
            charge_stamp_reg <= '1;
        end else if (accept) begin
            max_val_reg      <= max_val_next;
            max_stamp_reg    <= max_stamp_next;
            min_val_reg      <= min_val_next;
            min_stamp_reg    <= min_stamp_next;
            seen_reg         <= 1'b1;
            float_stamp_reg  <= float_stamp_next;
            charge_stamp_reg <= charge_stamp_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// File: sv/bvtm_checker.sv
// ----------------------------------------------------------------------------
// bvtm_checker
// Port-level checks on the trend monitor's result channel and flow control.
// ----------------------------------------------------------------------------
module bvtm_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input bvtm_pkg::out_item_t   m_data
);

    // a waiting result is held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item dropped or changed while stalled");

    // an empty output register never blocks intake
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("intake blocked with empty output register");

    a_graph_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.graph_valid |-> m_data.graph_code == bvtm_pkg::BAND_IDLE)
        else $error("graph code set outside a period end");

    a_avg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.avg_valid |-> m_data.avg_mv == '0)
        else $error("average set outside a window end");

    // a negative stamp can only be the never-seen marker
    a_float_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_float_time[bvtm_pkg::STAMP_W-1] |->
            m_data.last_float_time == '1)
        else $error("float stamp negative but not the none marker");

endmodule

bind battery_voltage_trend_monitor_top bvtm_checker u_bvtm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/tb_battery_voltage_trend_monitor_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_battery_voltage_trend_monitor_top
// Self-checking bench for the battery voltage trend monitor.
// A scoreboard class runs its own model of the 24 h max/min window, band
// stamps, six-sample mean and band state machine for every item taken in.
// It compares each result field by field. Directed items come first, then
// random minute ticks under several threshold and period settings.
// ----------------------------------------------------------------------------
import bvtm_pkg::*;

class trend_scoreboard;
    bit [MV_W-1:0]              float_thr;
    bit [MV_W-1:0]              charge_thr;
    bit [PERIOD_W-1:0]          period;

    bit [MV_W-1:0]              max_value;
    bit [SEC_W-1:0]             max_stamp;
    bit [MV_W-1:0]              min_value;
    bit [SEC_W-1:0]             min_stamp;
    bit                         seen_sample;
    logic signed [STAMP_W-1:0]  float_stamp;
    logic signed [STAMP_W-1:0]  charge_stamp;
    bit [MV_W-1:0]              recent [AVG_WINDOW];
    int                         slot;
    bit [8:0]                   ticks;
    band_code_t                 band_state;
    bit                         went_up;
    bit                         went_down;

    out_item_t                  pending_trends [$];
    int                         errors;
    int                         items_in;
    int                         results;
    int                         avg_count;
    int                         graph_count;
    bit [15:0]                  codes_seen;

    function new();
        float_thr    = FLOAT_THR_RST;
        charge_thr   = CHARGE_THR_RST;
        period       = PERIOD_RST;
        max_value    = '0;
        max_stamp    = '0;
        min_value    = '0;
        min_stamp    = '0;
        seen_sample  = 1'b0;
        float_stamp  = -1;
        charge_stamp = -1;
        foreach (recent[i]) recent[i] = '0;
        slot         = 0;
        ticks        = '0;
        band_state   = BAND_IDLE;
        went_up      = 1'b0;
        went_down    = 1'b0;
    endfunction

    function void set_reg(reg_idx_t idx, int unsigned value);
        case (idx)
            REG_FLOAT_THR:  float_thr  = value[MV_W-1:0];
            REG_CHARGE_THR: charge_thr = value[MV_W-1:0];
            REG_PERIOD:     period     = value[PERIOD_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return pending_trends.size();
    endfunction

    // band of the sample, then transition tracking; a clear drops the machine
    function band_code_t band_step(bit [MV_W-1:0] mv, bit clear);
        band_code_t code;
        if (mv >= charge_thr)
            code = BAND_CHARGE;
        else if (mv >= float_thr)
            code = BAND_FLOAT;
        else
            code = BAND_NOT;

        if (code == BAND_NOT && band_state == BAND_CHARGE) begin
            went_down = 1'b1;
            code = BAND_CHG_TO_NOT;
        end else if (code == BAND_FLOAT && band_state == BAND_CHARGE) begin
            went_down = 1'b1;
            code = BAND_CHG_TO_FLT;
        end else if (code == BAND_CHARGE && band_state == BAND_FLOAT) begin
            went_up = 1'b1;
            code = BAND_FLT_TO_CHG;
        end else if (code == BAND_CHARGE && band_state == BAND_NOT) begin
            went_up = 1'b1;
            code = BAND_NOT_TO_CHG;
        end
        if (went_up && went_down)
            code = BAND_UP_DOWN;
        if ((went_up || went_down) && band_state == BAND_UP_DOWN)
            code = BAND_MULTI;

        if (clear) begin
            band_state = BAND_IDLE;
            went_up    = 1'b0;
            went_down  = 1'b0;
        end else begin
            band_state = code;
        end
        return code;
    endfunction

    function void note_input(in_item_t it);
        out_item_t  want;
        bit [MV_W-1:0]  mv;
        bit [SEC_W-1:0] now;
        int unsigned    sum;
        band_code_t     code;

        mv  = it.sample_mv;
        now = it.now_seconds;
        want = '0;
        items_in++;

        if (!seen_sample) begin
            seen_sample = 1'b1;
            max_value = mv;
            max_stamp = now;
            min_value = mv;
            min_stamp = now;
        end else begin
            // signed difference: a clock that went back never expires the window
            if (mv > max_value ||
                (longint'(now) - longint'(max_stamp)) > longint'(WINDOW_SECONDS)) begin
                max_value = mv;
                max_stamp = now;
            end
            if (mv < min_value ||
                (longint'(now) - longint'(min_stamp)) > longint'(WINDOW_SECONDS)) begin
                min_value = mv;
                min_stamp = now;
            end
        end

        if (mv >= charge_thr)
            charge_stamp = {1'b0, now};
        else if (mv >= float_thr)
            float_stamp = {1'b0, now};

        if (slot >= AVG_WINDOW)
            slot = 0;
        recent[slot] = mv;
        slot++;
        if (slot >= AVG_WINDOW) begin
            sum = 0;
            foreach (recent[i]) sum += recent[i];
            want.avg_valid = 1'b1;
            want.avg_mv    = MV_W'(sum / AVG_WINDOW);
            slot = 0;
            avg_count++;
        end

        ticks = ticks + 9'd1;
        if (ticks < {1'b0, period}) begin
            void'(band_step(mv, 1'b0));
        end else begin
            ticks = '0;
            code = band_step(mv, 1'b1);
            want.graph_valid = 1'b1;
            want.graph_code  = code;
            codes_seen[code] = 1'b1;
            graph_count++;
        end

        want.max_mv           = max_value;
        want.min_mv           = min_value;
        want.last_float_time  = float_stamp;
        want.last_charge_time = charge_stamp;
        pending_trends.push_back(want);
    endfunction

    task report(string what);
        errors++;
        if (errors <= 40)
            $display("MISMATCH: %s", what);
    endtask

    task check_result(out_item_t got);
        out_item_t want;
        if (pending_trends.size() == 0) begin
            report("result arrived with no item pending");
            return;
        end
        want = pending_trends.pop_front();
        results++;
        if (got.max_mv !== want.max_mv)
            report($sformatf("result %0d max_mv got %0d want %0d",
                             results, got.max_mv, want.max_mv));
        if (got.min_mv !== want.min_mv)
            report($sformatf("result %0d min_mv got %0d want %0d",
                             results, got.min_mv, want.min_mv));
        if (got.last_float_time !== want.last_float_time)
            report($sformatf("result %0d last_float_time got %0d want %0d",
                             results, got.last_float_time, want.last_float_time));
        if (got.last_charge_time !== want.last_charge_time)
            report($sformatf("result %0d last_charge_time got %0d want %0d",
                             results, got.last_charge_time, want.last_charge_time));
        if (got.avg_valid !== want.avg_valid)
            report($sformatf("result %0d avg_valid got %b want %b",
                             results, got.avg_valid, want.avg_valid));
        if (got.avg_mv !== want.avg_mv)
            report($sformatf("result %0d avg_mv got %0d want %0d",
                             results, got.avg_mv, want.avg_mv));
        if (got.graph_valid !== want.graph_valid)
            report($sformatf("result %0d graph_valid got %b want %b",
                             results, got.graph_valid, want.graph_valid));
        if (got.graph_code !== want.graph_code)
            report($sformatf("result %0d graph_code got %0d want %0d",
                             results, got.graph_code, want.graph_code));
    endtask
endclass

module tb_battery_voltage_trend_monitor_top;

    localparam int unsigned CYCLE_LIMIT = 300000;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_valid  = 1'b0;
    logic                 s_ready;
    in_item_t             s_data   = '0;
    logic                 m_valid;
    logic                 m_ready  = 1'b0;
    out_item_t            m_data;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    trend_scoreboard      sb;
    bit                   idle_on   = 1'b1;
    int                   ready_hold = 0;
    int unsigned          cycle_count = 0;
    int                   reg_writes = 0;
    bit [SEC_W-1:0]       walk_now;

    battery_voltage_trend_monitor_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side backpressure in random bursts
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            ready_hold <= int'($urandom_range(1, 17)) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // item taken in first, so a same-edge result still finds its expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    task automatic send_pair(int mv, bit [SEC_W-1:0] now);
        in_item_t it;
        it.sample_mv   = MV_W'(mv);
        it.now_seconds = now;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for every pending result, then the output register latency
    task automatic settle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, value);
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_bands(int unsigned flt, int unsigned chg, int unsigned per);
        stop_sending();
        settle();
        write_reg(REG_FLOAT_THR, flt);
        write_reg(REG_CHARGE_THR, chg);
        write_reg(REG_PERIOD, per);
    endtask

    // mostly minute ticks hovering around the thresholds, plus day gaps,
    // clock steps back and fully random items
    task automatic send_random(int n);
        int pick;
        int mv;
        int base;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                walk_now = walk_now + SEC_W'(60);
                base = $urandom_range(0, 1) ? int'(sb.float_thr) : int'(sb.charge_thr);
                mv = base + int'($urandom_range(0, 600)) - 300;
            end else if (pick < 85) begin
                walk_now = walk_now + SEC_W'($urandom_range(86000, 90000));
                mv = $urandom_range(0, 32767);
            end else if (pick < 92) begin
                walk_now = walk_now - SEC_W'($urandom_range(1, 5000));
                mv = $urandom_range(0, 32767);
            end else begin
                walk_now = SEC_W'($urandom);
                mv = $urandom_range(0, 32767);
            end
            if (mv < 0)
                mv = 0;
            if (mv > 32767)
                mv = 32767;
            send_pair(mv, walk_now);
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: first sample, band walk, extremes, window expiry,
        // clock going back and threshold edges
        send_pair(13000, 31'd1000);
        send_pair(13500, 31'd1060);
        send_pair(14000, 31'd1120);
        send_pair(13500, 31'd1180);
        send_pair(14200, 31'd1240);
        send_pair(14300, 31'd1300);
        send_pair(12000, 31'd1360);
        send_pair(32767, 31'd1420);
        send_pair(0,     31'd1480);
        send_pair(13100, 31'd87881);
        send_pair(13100, 31'd87880);
        send_pair(13800, 31'h7FFFFFFF);
        send_pair(13199, 31'd0);
        send_pair(13200, 31'h55555555);
        send_pair(13799, 31'h2AAAAAAA);
        send_pair(21845, 31'd60);
        send_pair(10922, 31'd120);
        walk_now = 31'd180;
        send_random(50);

        // only 32767 reaches charge, everything else counts as float; period of one
        set_bands(0, 32767, 1);
        send_random(40);

        // overlapping thresholds, longest period
        set_bands(32767, 0, 255);
        send_random(60);

        // period dropped below the ticks already counted
        set_bands(13200, 13800, 7);
        send_random(40);

        // period zero ends on every item
        set_bands(13200, 13800, 0);
        send_random(30);

        for (int p = 0; p < 4; p++) begin
            set_bands($urandom_range(12800, 13600), $urandom_range(13400, 14200),
                      $urandom_range(1, 40));
            send_random(25);
            stop_sending();
            settle();
            send_random(20);
        end

        // closing stretch at full rate on both sides
        set_bands(13200, 13800, 12);
        idle_on = 1'b0;
        send_random(70);

        stop_sending();
        settle();
        repeat (10) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        $display("Covered %0d items, %0d results, %0d averages, %0d graph codes, %0d reg writes",
                 sb.items_in, sb.results, sb.avg_count, sb.graph_count, reg_writes);
        $display("Graph codes seen (bit per code): %b, mismatches: %0d",
                 sb.codes_seen[9:0], sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
